[rtl/core/ef_chi_pkg.sv]
// Shared constants and types of the epoch-folding chi-square unit.
`timescale 1ns / 1ps
`default_nettype none

package ef_chi_pkg;

  // Sizing of the bin store and of the run counter.
  localparam int MAX_PHASE_BINS = 64;
  localparam int MAX_SAMPLES    = 131072;
  localparam int MIN_PHASE_BINS = 4;

  // Fixed field widths of the ports.
  localparam int TIME_W      = 48;
  localparam int PERIOD_W    = 20;
  localparam int BINS_CFG_W  = 7;
  localparam int CHI_W       = 32;
  localparam int COUNT_OUT_W = 18;
  localparam int FRAC_W      = 8;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 1;

  // Register reset values.
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = PERIOD_W'(1000);
  localparam logic [BINS_CFG_W-1:0] BINS_RESET   = BINS_CFG_W'(64);

  // Derived widths.
  localparam int BIN_W   = $clog2(MAX_PHASE_BINS);
  localparam int EBINS_W = $clog2(MAX_PHASE_BINS + 1);
  localparam int CMP_W   = (BINS_CFG_W > EBINS_W) ? BINS_CFG_W : EBINS_W;
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMSQ_W = 2 * CNT_W;
  localparam int NUM_W   = SUMSQ_W + EBINS_W;
  localparam int DVD_W   = (TIME_W > NUM_W + FRAC_W) ? TIME_W : NUM_W + FRAC_W;
  localparam int DIVR_W  = (PERIOD_W > CNT_W) ? PERIOD_W : CNT_W;
  localparam int REM_W   = DIVR_W + 1;
  localparam int STEP_W  = $clog2(DVD_W + 1);
  localparam int PROD_W  = PERIOD_W + EBINS_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 1'b0,
    REG_BINS   = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_MUL,
    S_BINDIV,
    S_RD,
    S_WR,
    S_SRD,
    S_SSQ,
    S_SACC,
    S_NSQ,
    S_NUM,
    S_SUB,
    S_CHIDIV,
    S_EMIT
  } state_e;

  // Control strobes decoded from the sequencer state.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic mem_we;
    logic emit;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/epoch_folding_chi_square_unit.sv]
// Epoch-folding chi-square unit: folds event times into phase bins, emits chi-square.
// A plain word passes the phase modulo, the bin-count multiply and the bin division on
// the shared restoring divider (one quotient bit per cycle), then a store read and write;
// input stalls meanwhile. A word marked last then reads, squares and accumulates each bin
// in use, squares n, scales the sum, subtracts, divides on the divider unless the result
// clips to zero, and emits, after any wait for a result still held in the output.
// Throughput: one word at a time; the result register lets the next word in.
// Reset: asynchronous, active low; clears the sequencer, counters and bin valid bits.
`timescale 1ns / 1ps
`default_nettype none

module epoch_folding_chi_square_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [ef_chi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ef_chi_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input words.
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [ef_chi_pkg::TIME_W-1:0]        time_ns_i,
  input  wire logic                                 last_i,
  // Result words.
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [ef_chi_pkg::CHI_W-1:0]              chi_square_q8_o,
  output logic [ef_chi_pkg::COUNT_OUT_W-1:0]        sample_count_o,
  output logic                                      overflow_o
);

  localparam int BIN_W   = ef_chi_pkg::BIN_W;
  localparam int EBINS_W = ef_chi_pkg::EBINS_W;
  localparam int CMP_W   = ef_chi_pkg::CMP_W;
  localparam int CNT_W   = ef_chi_pkg::CNT_W;
  localparam int SUMSQ_W = ef_chi_pkg::SUMSQ_W;
  localparam int NUM_W   = ef_chi_pkg::NUM_W;
  localparam int DVD_W   = ef_chi_pkg::DVD_W;
  localparam int DIVR_W  = ef_chi_pkg::DIVR_W;
  localparam int REM_W   = ef_chi_pkg::REM_W;
  localparam int STEP_W  = ef_chi_pkg::STEP_W;
  localparam int PROD_W  = ef_chi_pkg::PROD_W;
  localparam int TIME_W  = ef_chi_pkg::TIME_W;
  localparam int PERIOD_W = ef_chi_pkg::PERIOD_W;
  localparam int CHI_W   = ef_chi_pkg::CHI_W;
  localparam int FRAC_W  = ef_chi_pkg::FRAC_W;

  ef_chi_pkg::state_e state_q, state_d;
  ef_chi_pkg::ctrl_t  ctrl;

  logic [PERIOD_W-1:0]                   period_q;
  logic [ef_chi_pkg::BINS_CFG_W-1:0]     bins_cfg_q;

  logic                      have_origin_q, have_origin_d;
  logic [TIME_W-1:0]         origin_q, origin_d;
  logic [CNT_W-1:0]          run_count_q, run_count_d;
  logic                      overflow_seen_q, overflow_seen_d;
  logic                      last_q, last_d;
  logic [ef_chi_pkg::MAX_PHASE_BINS-1:0] valid_q, valid_d;

  logic [REM_W-1:0]          rem_q, rem_d;
  logic [DVD_W-1:0]          dvd_q, dvd_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic [BIN_W-1:0]          sum_idx_q, sum_idx_d;
  logic [SUMSQ_W-1:0]        sq_q, sq_d;
  logic [SUMSQ_W-1:0]        acc_q, acc_d;
  logic [NUM_W-1:0]          num_q, num_d;

  logic                      out_valid_q;
  logic [CHI_W-1:0]          chi_q;
  logic [CNT_W-1:0]          count_out_q;
  logic                      ovf_out_q;

  // Effective bin count, clamped to the supported range.
  logic [CMP_W-1:0]   bins_raw;
  logic [EBINS_W-1:0] bins_eff;
  always_comb begin
    bins_raw = CMP_W'(bins_cfg_q);
    if (bins_raw < CMP_W'(ef_chi_pkg::MIN_PHASE_BINS)) begin
      bins_eff = EBINS_W'(ef_chi_pkg::MIN_PHASE_BINS);
    end else if (bins_raw > CMP_W'(ef_chi_pkg::MAX_PHASE_BINS)) begin
      bins_eff = EBINS_W'(ef_chi_pkg::MAX_PHASE_BINS);
    end else begin
      bins_eff = EBINS_W'(bins_raw);
    end
  end

  // A zero period folds as a period of one.
  logic [PERIOD_W-1:0] period_eff;
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

  // Shared restoring divider step: one quotient bit per cycle.
  logic [DIVR_W-1:0] div_divisor;
  logic [REM_W-1:0]  rem_sh;
  logic              div_ge;
  logic [REM_W-1:0]  rem_nx;
  logic [DVD_W-1:0]  dvd_nx;
  assign div_divisor = (state_q == ef_chi_pkg::S_CHIDIV) ? DIVR_W'(run_count_q)
                                                          : DIVR_W'(period_eff);
  assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
  assign div_ge = (rem_sh >= {1'b0, div_divisor});
  assign rem_nx = div_ge ? (rem_sh - {1'b0, div_divisor}) : rem_sh;
  assign dvd_nx = {dvd_q[DVD_W-2:0], div_ge};

  // Bin store: read port registered, valid bits mark entries written this run.
  logic [CNT_W-1:0] bin_mem [ef_chi_pkg::MAX_PHASE_BINS];
  logic [BIN_W-1:0] bin_addr;
  logic [BIN_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_data_q;
  logic             rd_valid_q;
  logic [CNT_W-1:0] rd_count;
  assign bin_addr = dvd_q[BIN_W-1:0];
  assign rd_addr  = (state_q == ef_chi_pkg::S_RD) ? bin_addr : sum_idx_q;
  assign rd_count = rd_valid_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl.mem_we) begin
      bin_mem[bin_addr] <= rd_count + CNT_W'(1);
    end
    rd_data_q  <= bin_mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
  end

  // Shared squarer: bin counts during the sum, then the sample count.
  logic [CNT_W-1:0] sq_a;
  assign sq_a = (state_q == ef_chi_pkg::S_NSQ) ? run_count_q : rd_count;

  // Misc combinational values.
  logic [TIME_W-1:0] offset;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  diff;
  logic              at_max;
  logic              sum_end;
  logic              num_gt;
  logic              step_last;
  assign offset    = time_ns_i - (have_origin_q ? origin_q : time_ns_i);
  assign prod      = PROD_W'(rem_q[PERIOD_W-1:0]) * PROD_W'(bins_eff);
  assign diff      = num_q - NUM_W'(sq_q);
  assign at_max    = (run_count_q >= CNT_W'(ef_chi_pkg::MAX_SAMPLES));
  assign sum_end   = (EBINS_W'(sum_idx_q) == (bins_eff - EBINS_W'(1)));
  assign num_gt    = (num_q > NUM_W'(sq_q));
  assign step_last = (step_q == STEP_W'(1));

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ef_chi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (!at_max) begin
            state_d = ef_chi_pkg::S_MOD;
          end else if (last_i) begin
            state_d = ef_chi_pkg::S_SRD;
          end
        end
      end
      ef_chi_pkg::S_MOD: begin
        if (step_last) state_d = ef_chi_pkg::S_MUL;
      end
      ef_chi_pkg::S_MUL:    state_d = ef_chi_pkg::S_BINDIV;
      ef_chi_pkg::S_BINDIV: begin
        if (step_last) state_d = ef_chi_pkg::S_RD;
      end
      ef_chi_pkg::S_RD:     state_d = ef_chi_pkg::S_WR;
      ef_chi_pkg::S_WR:     state_d = last_q ? ef_chi_pkg::S_SRD : ef_chi_pkg::S_IDLE;
      ef_chi_pkg::S_SRD:    state_d = ef_chi_pkg::S_SSQ;
      ef_chi_pkg::S_SSQ:    state_d = ef_chi_pkg::S_SACC;
      ef_chi_pkg::S_SACC:   state_d = sum_end ? ef_chi_pkg::S_NSQ : ef_chi_pkg::S_SRD;
      ef_chi_pkg::S_NSQ:    state_d = ef_chi_pkg::S_NUM;
      ef_chi_pkg::S_NUM:    state_d = ef_chi_pkg::S_SUB;
      ef_chi_pkg::S_SUB:    state_d = num_gt ? ef_chi_pkg::S_CHIDIV : ef_chi_pkg::S_EMIT;
      ef_chi_pkg::S_CHIDIV: begin
        if (step_last) state_d = ef_chi_pkg::S_EMIT;
      end
      ef_chi_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) state_d = ef_chi_pkg::S_IDLE;
      end
      default: state_d = ef_chi_pkg::S_IDLE;
    endcase
  end

  // Sequencer control strobes.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ef_chi_pkg::S_IDLE:   ctrl.accept = in_valid_i;
      ef_chi_pkg::S_MOD,
      ef_chi_pkg::S_BINDIV,
      ef_chi_pkg::S_CHIDIV: ctrl.div_step = 1'b1;
      ef_chi_pkg::S_WR:     ctrl.mem_we = 1'b1;
      ef_chi_pkg::S_EMIT:   ctrl.emit = !out_valid_q || !out_stall_i;
      default: ctrl = '0;
    endcase
  end

  assign in_stall_o = (state_q != ef_chi_pkg::S_IDLE);

  // Datapath next values.
  always_comb begin
    have_origin_d   = have_origin_q;
    origin_d        = origin_q;
    run_count_d     = run_count_q;
    overflow_seen_d = overflow_seen_q;
    last_d          = last_q;
    valid_d         = valid_q;
    rem_d           = rem_q;
    dvd_d           = dvd_q;
    step_d          = step_q;
    sum_idx_d       = sum_idx_q;
    sq_d            = sq_q;
    acc_d           = acc_q;
    num_d           = num_q;

    if (ctrl.div_step) begin
      rem_d  = rem_nx;
      dvd_d  = dvd_nx;
      step_d = step_q - STEP_W'(1);
    end

    // Accept: take the origin, then fold or count the word as overflow.
    if (ctrl.accept) begin
      last_d    = last_i;
      sum_idx_d = '0;
      acc_d     = '0;
      if (!have_origin_q) begin
        have_origin_d = 1'b1;
        origin_d      = time_ns_i;
      end
      if (at_max) begin
        overflow_seen_d = 1'b1;
      end else begin
        rem_d  = '0;
        dvd_d  = DVD_W'(offset);
        step_d = STEP_W'(DVD_W);
      end
    end

    // Scale the phase by the bin count, then divide by the period.
    if (state_q == ef_chi_pkg::S_MUL) begin
      rem_d  = REM_W'(prod >> EBINS_W);
      dvd_d  = {prod[EBINS_W-1:0], {(DVD_W - EBINS_W){1'b0}}};
      step_d = STEP_W'(EBINS_W);
    end

    // Bin count increments with the store write.
    if (ctrl.mem_we) begin
      valid_d[bin_addr] = 1'b1;
      run_count_d       = run_count_q + CNT_W'(1);
    end

    // Sum of squared counts over the bins in use.
    if (state_q == ef_chi_pkg::S_SSQ || state_q == ef_chi_pkg::S_NSQ) begin
      sq_d = SUMSQ_W'(sq_a) * SUMSQ_W'(sq_a);
    end
    if (state_q == ef_chi_pkg::S_SACC) begin
      acc_d     = acc_q + sq_q;
      sum_idx_d = sum_idx_q + BIN_W'(1);
    end
    if (state_q == ef_chi_pkg::S_NUM) begin
      num_d = NUM_W'(acc_q) * NUM_W'(bins_eff);
    end

    // Chi-square numerator, scaled by the fraction bits, or zero.
    if (state_q == ef_chi_pkg::S_SUB) begin
      rem_d  = '0;
      step_d = STEP_W'(DVD_W);
      dvd_d  = num_gt ? (DVD_W'(diff) << FRAC_W) : '0;
    end

    // Emission clears the run.
    if (ctrl.emit) begin
      have_origin_d   = 1'b0;
      origin_d        = '0;
      run_count_d     = '0;
      overflow_seen_d = 1'b0;
      valid_d         = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ef_chi_pkg::S_IDLE;
      period_q        <= ef_chi_pkg::PERIOD_RESET;
      bins_cfg_q      <= ef_chi_pkg::BINS_RESET;
      have_origin_q   <= 1'b0;
      origin_q        <= '0;
      run_count_q     <= '0;
      overflow_seen_q <= 1'b0;
      valid_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      have_origin_q   <= have_origin_d;
      origin_q        <= origin_d;
      run_count_q     <= run_count_d;
      overflow_seen_q <= overflow_seen_d;
      valid_q         <= valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == ef_chi_pkg::REG_PERIOD) begin
          period_q <= cfg_data_i[PERIOD_W-1:0];
        end else if (cfg_index_i == ef_chi_pkg::REG_BINS) begin
          bins_cfg_q <= cfg_data_i[ef_chi_pkg::BINS_CFG_W-1:0];
        end
      end
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    step_q    <= step_d;
    sum_idx_q <= sum_idx_d;
    sq_q      <= sq_d;
    acc_q     <= acc_d;
    num_q     <= num_d;
    if (ctrl.emit) begin
      chi_q       <= (|dvd_q[DVD_W-1:CHI_W]) ? '1 : dvd_q[CHI_W-1:0];
      count_out_q <= run_count_q;
      ovf_out_q   <= overflow_seen_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chi_square_q8_o = chi_q;
  assign sample_count_o  = ef_chi_pkg::COUNT_OUT_W'(count_out_q);
  assign overflow_o      = ovf_out_q;

  // The run counter never passes its saturation point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_count_q <= CNT_W'(ef_chi_pkg::MAX_SAMPLES))
    else $error("run counter above saturation");

  // The divider remainder stays below the divisor while dividing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ef_chi_pkg::S_MOD || state_q == ef_chi_pkg::S_BINDIV ||
     state_q == ef_chi_pkg::S_CHIDIV) |-> (rem_q < {1'b0, div_divisor}))
    else $error("divider remainder not below divisor");

  // The bin being updated lies within the bins in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ef_chi_pkg::S_WR) |-> (EBINS_W'(bin_addr) < bins_eff))
    else $error("bin index out of range");

  // Emitting a result leaves a cleared run behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> (out_valid_q && !have_origin_q && run_count_q == '0 && valid_q == '0))
    else $error("run not cleared after emission");

endmodule

`default_nettype wire

[tb/epoch_folding_chi_square_unit_test.sv]
// Self-checking testbench for the epoch-folding chi-square unit.
`timescale 1ns / 1ps

module epoch_folding_chi_square_unit_test;

  import ef_chi_pkg::*;

  localparam int unsigned WORD_TARGET  = 1850;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  // Settle waits, long enough for a plain word and for a run end to finish.
  localparam int unsigned IDLE_SETTLE  = 80;
  localparam int unsigned FINAL_SETTLE = 400;

  // One result word as the unit presents it.
  typedef struct packed {
    logic [CHI_W-1:0]       chi;
    logic [COUNT_OUT_W-1:0] count;
    logic                   ovf;
  } fold_result_t;

  // Folds accepted words into its own bin store and keeps the results still due.
  class fold_scoreboard;
    logic [PERIOD_W-1:0]   period;
    logic [BINS_CFG_W-1:0] bins_cfg;
    int unsigned           bin_count [MAX_PHASE_BINS];
    logic [TIME_W-1:0]     origin;
    bit                    have_origin;
    int unsigned           run_count;
    bit                    overflow_seen;
    fold_result_t          due [$];
    int unsigned           words;
    int unsigned           runs;
    int unsigned           results;
    int unsigned           mismatches;

    function new();
      period     = PERIOD_RESET;
      bins_cfg   = BINS_RESET;
      words      = 0;
      runs       = 0;
      results    = 0;
      mismatches = 0;
      clear_run();
    endfunction

    function void clear_run();
      foreach (bin_count[i]) bin_count[i] = 0;
      origin        = '0;
      have_origin   = 1'b0;
      run_count     = 0;
      overflow_seen = 1'b0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PERIOD: period = value[PERIOD_W-1:0];
        REG_BINS:   bins_cfg = value[BINS_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // The bin setting is clamped into the range the store supports.
    function int unsigned bins_in_use();
      int unsigned nb;
      nb = bins_cfg;
      if (nb < MIN_PHASE_BINS) nb = MIN_PHASE_BINS;
      if (nb > MAX_PHASE_BINS) nb = MAX_PHASE_BINS;
      return nb;
    endfunction

    // Chi-square against a flat phase profile, bins*sum(c^2)/n - n, in Q24.8.
    function logic [CHI_W-1:0] chi_square(int unsigned nb, int unsigned n);
      longint unsigned c;
      longint unsigned nn;
      longint unsigned sum_sq;
      longint unsigned num;
      longint unsigned nsq;
      longint unsigned d;
      longint unsigned whole;
      longint unsigned frac;
      if (n == 0) return '0;
      nn = n;
      sum_sq = 0;
      for (int unsigned i = 0; i < nb; i++) begin
        c = bin_count[i];
        sum_sq += c * c;
      end
      num = sum_sq * nb;
      nsq = nn * nn;
      if (num <= nsq) return '0;
      d = num - nsq;
      whole = d / nn;
      if (whole > 64'hFF_FFFF) return '1;
      frac = ((d % nn) << FRAC_W) / nn;
      return CHI_W'((whole << FRAC_W) + frac);
    endfunction

    // Folds one accepted word; a word marked last closes the run.
    function void note_word(logic [TIME_W-1:0] t, logic l);
      int unsigned       nb;
      int unsigned       p;
      int unsigned       bin;
      logic [TIME_W-1:0] off;
      longint unsigned   phase;
      fold_result_t      r;
      words++;
      nb = bins_in_use();
      if (!have_origin) begin
        origin = t;
        have_origin = 1'b1;
      end
      if (run_count >= MAX_SAMPLES) begin
        overflow_seen = 1'b1;
      end else begin
        p = (period == 0) ? 1 : period;
        off = t - origin;
        phase = off % p;
        bin = int'((phase * nb) / p);
        if (bin >= nb) bin = nb - 1;
        bin_count[bin]++;
        run_count++;
      end
      if (l) begin
        r.chi   = chi_square(nb, run_count);
        r.count = COUNT_OUT_W'(run_count);
        r.ovf   = overflow_seen;
        due.insert(due.size(), r);
        runs++;
        clear_run();
      end
    endfunction

    // Compares one accepted result word with the oldest one due.
    function void check_result(fold_result_t got);
      fold_result_t want;
      results++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result with none due: chi_square_q8=%0d sample_count=%0d overflow=%0d",
                   got.chi, got.count, got.ovf);
        return;
      end
      want = due.pop_front();
      if (got.chi !== want.chi || got.count !== want.count || got.ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result %0d mismatch: expected chi_square_q8=%0d sample_count=%0d overflow=%0d",
                   results, want.chi, want.count, want.ovf);
          $display("  got chi_square_q8=%0d sample_count=%0d overflow=%0d",
                   got.chi, got.count, got.ovf);
        end
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_PERIOD;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TIME_W-1:0]       time_ns = '0;
  logic                    last_flag = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CHI_W-1:0]        chi_square_q8;
  logic [COUNT_OUT_W-1:0]  sample_count;
  logic                    overflow;

  fold_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    reg_writes = 0;
  bit             send_burst = 1'b0;

  epoch_folding_chi_square_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .time_ns_i       (time_ns),
    .last_i          (last_flag),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .chi_square_q8_o (chi_square_q8),
    .sample_count_o  (sample_count),
    .overflow_o      (overflow)
  );

  // Clock and cycle count.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results still due", cycle_count, sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, with and without a word waiting, and calm stretches.
  initial begin : result_sink
    int unsigned  hold;
    bit           calm;
    fold_result_t got;
    hold = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        got.chi   = chi_square_q8;
        got.count = sample_count;
        got.ovf   = overflow;
        sb.check_result(got);
        if ($urandom_range(0, 29) == 0) calm = ~calm;
        hold = calm ? 0 : $urandom_range(0, 17);
      end
      @(negedge clk_i);
      if (out_valid) begin
        if (hold > 0) begin
          out_stall <= 1'b1;
          hold--;
        end else begin
          out_stall <= 1'b0;
        end
      end else begin
        out_stall <= (!calm && $urandom_range(0, 3) == 0);
      end
    end
  end

  // Presents one word after a random gap and waits until the unit takes it.
  task automatic send_word(input logic [TIME_W-1:0] t, input logic l);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    time_ns   <= t;
    last_flag <= l;
    do @(posedge clk_i); while (in_stall);
    sb.note_word(t, l);
    @(negedge clk_i);
  endtask

  // Register writes wait until the unit has drained and settled.
  task automatic reconfigure(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
    reg_writes++;
    @(negedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 20'hF_FFFF;
      2, 3:    return CFG_DATA_W'($urandom_range(1, 20));
      4, 5, 6: return CFG_DATA_W'($urandom_range(20, 5000));
      default: return CFG_DATA_W'($urandom_range(1, 20'hF_FFFF));
    endcase
  endfunction

  // Bin settings, upper data bits random since only the low seven bits count.
  function automatic logic [CFG_DATA_W-1:0] pick_bins();
    logic [BINS_CFG_W-1:0] b;
    case ($urandom_range(0, 9))
      0:       b = BINS_CFG_W'($urandom_range(0, 3));
      1:       b = BINS_CFG_W'($urandom_range(65, 127));
      2:       b = BINS_CFG_W'(MAX_PHASE_BINS);
      3:       b = BINS_CFG_W'(MIN_PHASE_BINS);
      default: b = BINS_CFG_W'($urandom_range(4, 64));
    endcase
    return {(CFG_DATA_W - BINS_CFG_W)'($urandom), b};
  endfunction

  task automatic reconfigure_random();
    int unsigned pick;
    pick = $urandom_range(0, 2);
    if (pick != 1) reconfigure(REG_PERIOD, pick_period());
    if (pick != 0) reconfigure(REG_BINS, pick_bins());
  endtask

  function automatic logic [TIME_W-1:0] pick_origin();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 100000));
      default: return TIME_W'({$urandom, $urandom});
    endcase
  endfunction

  // Mostly ascending steps of a few periods; now and then far jumps or a step back.
  function automatic logic [TIME_W-1:0] next_step();
    int unsigned p;
    p = (sb.period == 0) ? 1 : sb.period;
    case ($urandom_range(0, 19))
      0:       return TIME_W'({$urandom, $urandom});
      1:       return -TIME_W'($urandom_range(1, 5000));
      2:       return '0;
      3:       return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(0, 3 * p));
    endcase
  endfunction

  // One run of random times, sometimes with a register change partway through.
  task automatic fold_run(input int unsigned len);
    logic [TIME_W-1:0] t;
    int unsigned       split;
    split = (len > 1 && $urandom_range(0, 24) == 0) ? $urandom_range(1, len - 1) : 0;
    t = pick_origin();
    for (int unsigned k = 0; k < len; k++) begin
      if (split != 0 && k == split) reconfigure_random();
      send_word(t, k == len - 1);
      t = t + next_step();
    end
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned len;
    int unsigned leftover;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings; times from zero up to the all-ones time.
    send_word(48'd0, 1'b0);
    send_word(48'd500, 1'b0);
    send_word(48'd999, 1'b0);
    send_word(48'd1000, 1'b0);
    send_word(48'hFFFF_FFFF_FFFF, 1'b1);

    // A zero period folds everything into phase zero.
    reconfigure(REG_PERIOD, 20'd0);
    reconfigure(REG_BINS, 20'd4);
    send_word(48'd123, 1'b0);
    send_word(48'd456, 1'b0);
    send_word(48'd789, 1'b1);

    // Largest period; a bin setting above the store size acts as the store size.
    reconfigure(REG_PERIOD, 20'hF_FFFF);
    reconfigure(REG_BINS, 20'd127);
    send_word(48'hAAAA_AAAA_AAAA, 1'b0);
    send_word(48'hAAAA_AAB2_AAAA, 1'b0);
    send_word(48'hAAAA_AABA_AAA8, 1'b0);
    send_word(48'hAAAA_AABA_AAA9, 1'b1);

    // Bin setting below the minimum, and a run of a single word.
    reconfigure(REG_PERIOD, 20'd1);
    reconfigure(REG_BINS, 20'd2);
    send_word(48'd7, 1'b1);

    // Bin count raised partway through a run.
    reconfigure(REG_PERIOD, 20'd100);
    reconfigure(REG_BINS, 20'd4);
    send_word(48'd0, 1'b0);
    send_word(48'd10, 1'b0);
    send_word(48'd30, 1'b0);
    reconfigure(REG_BINS, 20'd64);
    send_word(48'd60, 1'b1);

    // Bin count lowered partway through, so the result comes out negative and clips to zero.
    reconfigure(REG_PERIOD, 20'd128);
    send_word(48'd0, 1'b0);
    send_word(48'd20, 1'b0);
    send_word(48'd40, 1'b0);
    reconfigure(REG_BINS, 20'd4);
    send_word(48'd70, 1'b1);

    // Store must be clear again; descending times wrap.
    reconfigure(REG_BINS, 20'd64);
    send_word(48'd1000, 1'b0);
    send_word(48'd900, 1'b0);
    send_word(48'd5, 1'b1);

    // Random runs.
    while (sb.words < WORD_TARGET) begin
      send_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) reconfigure_random();
      case ($urandom_range(0, 19))
        0:             len = $urandom_range(60, 150);
        1, 2, 3, 4, 5: len = $urandom_range(13, 40);
        default:       len = $urandom_range(1, 12);
      endcase
      fold_run(len);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (FINAL_SETTLE) @(negedge clk_i);

    leftover = sb.pending();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("Folded %0d words in %0d runs over %0d register writes; %0d results checked.",
             sb.words, sb.runs, reg_writes, sb.results);
    $display("Settings included zero and full-scale periods, clamped bin counts and mid-run changes.");
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatching results", sb.mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
